/* design/pnd_pkg.sv */
// shared types and constants for the petri net dead marking checker
// used by pnd_ctrl, pnd_dpath and petri_net_dead_marking_check_core
package pnd_pkg;

  // wide enough for a transition count or place count up to 64
  localparam int unsigned CntW     = 7;
  localparam int unsigned PlaceW   = 32;
  localparam int unsigned TidxW    = 5;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgInitMarking = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPlaceCount  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTransCount  = 2'd2;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpCheck = 1'b1;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StScan   = 4'b0010,
    StDrain  = 4'b0100,
    StFinish = 4'b1000
  } state_e;

  typedef struct packed {
    logic            load_we;
    logic            start;
    logic            rd_en;
    logic [CntW-1:0] rd_addr;
    logic            finish;
  } cmd_t;

  typedef struct packed {
    logic [CntW-1:0] tc_eff;
  } sts_t;

endpackage

/* design/pnd_ctrl.sv */
// controller state machine: item handshakes, table scan sequencing, result slot
// depends on pnd_pkg
module pnd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic          op_i,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  pnd_pkg::sts_t sts_i,
  output pnd_pkg::cmd_t cmd_o
);
  import pnd_pkg::*;

  state_e          state_q, state_d;
  logic [CntW-1:0] t_q, t_d;
  logic            out_valid_q, out_valid_d;
  logic            in_acc;

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  always_comb begin
    state_d       = state_q;
    t_d           = t_q;
    out_valid_d   = out_valid_q;
    cmd_o         = '0;
    cmd_o.rd_addr = t_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (op_i == OpLoad) begin
            cmd_o.load_we = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            t_d         = '0;
            if (sts_i.tc_eff == '0) begin
              state_d = StFinish;
            end else begin
              state_d = StScan;
            end
          end
        end
      end
      StScan: begin
        cmd_o.rd_en = 1'b1;
        t_d         = t_q + CntW'(1);
        if (t_q == sts_i.tc_eff - CntW'(1)) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StFinish;
      end
      StFinish: begin
        if (!out_valid_q || m_axis_tready) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      t_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      t_q         <= t_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* design/pnd_dpath.sv */
// datapath: configuration registers, transition mask memory, enable count and
// final marking evaluation, result register; depends on pnd_pkg
module pnd_dpath #(
  parameter int unsigned MAX_PLACES      = 32,
  parameter int unsigned MAX_TRANSITIONS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pnd_pkg::cmd_t                  cmd_i,
  output pnd_pkg::sts_t                  sts_o,
  input  logic                           cfg_valid_i,
  input  logic [pnd_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [pnd_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic [pnd_pkg::TidxW-1:0]      trans_idx_i,
  input  logic [pnd_pkg::PlaceW-1:0]     in_mask_i,
  input  logic [pnd_pkg::PlaceW-1:0]     out_mask_i,
  input  logic [pnd_pkg::PlaceW-1:0]     marking_i,
  output logic [5:0]                     enabled_count_o,
  output logic                           is_dead_o,
  output logic                           is_final_o,
  output logic                           is_deadlock_o
);
  import pnd_pkg::*;

  localparam int unsigned IdxW  = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
  localparam int unsigned PlLim = (MAX_PLACES < PlaceW) ? MAX_PLACES : PlaceW;

  logic [PlaceW-1:0]   init_mark_q;
  logic [5:0]          place_cnt_q;
  logic [5:0]          trans_cnt_q;

  logic [2*PlaceW-1:0] mem [MAX_TRANSITIONS];
  logic [2*PlaceW-1:0] rd_q;
  logic                rd_vld_q;
  logic [CntW-1:0]     widx;

  logic [PlaceW-1:0]   mark_q;
  logic [PlaceW-1:0]   used_q;
  logic [CntW-1:0]     count_q;

  logic [CntW-1:0]     n_places;
  logic [PlaceW-1:0]   pm;
  logic [PlaceW-1:0]   im, om, sinks;
  logic                t_enabled;
  logic                dead, fin;

  logic [5:0]          res_count_q;
  logic                res_dead_q, res_final_q, res_dl_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_mark_q <= '0;
      place_cnt_q <= 6'd32;
      trans_cnt_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgInitMarking: init_mark_q <= cfg_data_i;
        CfgPlaceCount:  place_cnt_q <= cfg_data_i[5:0];
        CfgTransCount:  trans_cnt_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if ({1'b0, trans_cnt_q} > CntW'(MAX_TRANSITIONS)) begin
      sts_o.tc_eff = CntW'(MAX_TRANSITIONS);
    end else begin
      sts_o.tc_eff = {1'b0, trans_cnt_q};
    end
    if ({1'b0, place_cnt_q} > CntW'(PlLim)) begin
      n_places = CntW'(PlLim);
    end else begin
      n_places = {1'b0, place_cnt_q};
    end
    for (int p = 0; p < PlaceW; p++) begin
      pm[p] = (CntW'(p) < n_places);
    end
  end

  // transition mask memory
  assign widx = {{(CntW-TidxW){1'b0}}, trans_idx_i};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we && (widx < CntW'(MAX_TRANSITIONS))) begin
      mem[widx[IdxW-1:0]] <= {out_mask_i, in_mask_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_q <= mem[cmd_i.rd_addr[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
    end
  end

  // per-entry enable test
  assign im        = rd_q[PlaceW-1:0] & pm;
  assign om        = rd_q[2*PlaceW-1:PlaceW] & pm;
  assign t_enabled = ((im & ~mark_q) == '0) && ((om & ~im & mark_q) == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mark_q  <= marking_i & pm;
      used_q  <= '0;
      count_q <= '0;
    end else if (rd_vld_q) begin
      used_q  <= used_q | im;
      count_q <= count_q + CntW'(t_enabled);
    end
  end

  // final marking test
  assign sinks = pm & ~used_q;
  assign dead  = (count_q == '0);

  always_comb begin
    if (mark_q == '0) begin
      fin = ((init_mark_q & pm) != '0);
    end else begin
      fin = (sinks != '0) && ((mark_q & ~sinks) == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_count_q <= count_q[5:0];
      res_dead_q  <= dead;
      res_final_q <= fin;
      res_dl_q    <= dead & ~fin;
    end
  end

  assign enabled_count_o = res_count_q;
  assign is_dead_o       = res_dead_q;
  assign is_final_o      = res_final_q;
  assign is_deadlock_o   = res_dl_q;

endmodule

/* design/petri_net_dead_marking_check_core.sv */
// dead marking checker for a 1-safe petri net; depends on pnd_pkg, pnd_ctrl, pnd_dpath
// load item: written into the mask memory when accepted; loads may follow back to back
// check item: one mask memory read per transition, then a drain state; the result is
//   registered in the finish state once the result slot is free (scan and drain are
//   skipped if the count is zero); the next item is taken only once idle again
// reset: asynchronous active low, resets control state and config registers (place count to 32)
module petri_net_dead_marking_check_core #(
  parameter int unsigned MAX_PLACES      = 32,
  parameter int unsigned MAX_TRANSITIONS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // transition_index, input_place_mask, output_place_mask, marking_bits
  input  logic [pnd_pkg::InDataW-1:0]        s_axis_tdata,
  // operation
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // enabled_count, is_dead, is_final, is_deadlock
  output logic [pnd_pkg::OutDataW-1:0]       m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pnd_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [pnd_pkg::CfgDataW-1:0]       cfg_data_i
);
  import pnd_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  logic [5:0] enabled_count;
  logic       is_dead, is_final, is_deadlock;

  assign cfg_ready_o = 1'b1;

  pnd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .op_i          (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  pnd_dpath #(
    .MAX_PLACES      (MAX_PLACES),
    .MAX_TRANSITIONS (MAX_TRANSITIONS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .trans_idx_i     (s_axis_tdata[4:0]),
    .in_mask_i       (s_axis_tdata[36:5]),
    .out_mask_i      (s_axis_tdata[68:37]),
    .marking_i       (s_axis_tdata[100:69]),
    .enabled_count_o (enabled_count),
    .is_dead_o       (is_dead),
    .is_final_o      (is_final),
    .is_deadlock_o   (is_deadlock)
  );

  assign m_axis_tdata = {7'b0, is_deadlock, is_final, is_dead, enabled_count};

endmodule

/* dv/tb.sv */
// testbench for petri_net_dead_marking_check_core: loads transition tables, checks markings
// and compares each verdict with an in-bench predictor; depends on pnd_pkg and the core rtl
// runs reset-state checks, directed nets, back-pressure, then random nets under four idling phases
module tb;
  import pnd_pkg::*;

  localparam int unsigned NumTrans     = 32;
  localparam int unsigned SettleCycles = 45;
  localparam int unsigned CycleLimit   = 400000;

  typedef struct packed {
    logic       is_deadlock;
    logic       is_final;
    logic       is_dead;
    logic [5:0] enabled_count;
  } verdict_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // transition_index, input_place_mask, output_place_mask, marking_bits
  logic [InDataW-1:0]  s_axis_tdata;
  // operation
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // enabled_count, is_dead, is_final, is_deadlock
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  logic [31:0] init_marking_q;
  logic [5:0]  place_count_q;
  logic [5:0]  trans_count_q;
  logic [31:0] in_mask_tbl [NumTrans];
  logic [31:0] out_mask_tbl[NumTrans];
  verdict_t    expected_verdicts[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_left;
  int unsigned cycle_count;
  int unsigned mismatch_count;

  petri_net_dead_marking_check_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] live_places();
    int unsigned n;
    n = (place_count_q > 32) ? 32 : place_count_q;
    if (n == 0) return '0;
    if (n == 32) return '1;
    return (32'h1 << n) - 32'h1;
  endfunction

  function automatic int unsigned live_transitions();
    return (trans_count_q > NumTrans) ? NumTrans : trans_count_q;
  endfunction

  function automatic logic [31:0] sink_set();
    logic [31:0] fed;
    fed = '0;
    for (int unsigned t = 0; t < live_transitions(); t++) fed |= in_mask_tbl[t];
    return live_places() & ~fed;
  endfunction

  function automatic verdict_t eval_marking(input logic [31:0] marking);
    verdict_t    v;
    logic [31:0] pm, mark, im, om, sinks;
    int unsigned cnt;
    pm    = live_places();
    mark  = marking & pm;
    sinks = sink_set();
    cnt   = 0;
    for (int unsigned t = 0; t < live_transitions(); t++) begin
      im = in_mask_tbl[t] & pm;
      om = out_mask_tbl[t] & pm;
      if ((im & ~mark) == '0 && (om & ~im & mark) == '0) cnt++;
    end
    v.enabled_count = 6'(cnt);
    v.is_dead       = (cnt == 0);
    if (mark == '0) v.is_final = ((init_marking_q & pm) != '0);
    else v.is_final = (sinks != '0) && ((mark & ~sinks) == '0);
    v.is_deadlock = v.is_dead && !v.is_final;
    return v;
  endfunction

  // few places from the live range (all 32 when the place count is zero), sometimes with noise above it
  function automatic logic [31:0] sparse_mask(input int unsigned max_bits);
    logic [31:0] m;
    int unsigned span;
    span = (place_count_q == 0 || place_count_q > 32) ? 32 : place_count_q;
    m = '0;
    repeat ($urandom_range(max_bits)) m[$urandom_range(span - 1)] = 1'b1;
    if ($urandom_range(6) == 0) m |= $urandom & ~live_places();
    return m;
  endfunction

  function automatic logic [31:0] next_marking();
    logic [31:0] pm, sinks, im, blocked, mk;
    int unsigned t;
    pm    = live_places();
    sinks = sink_set();
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        if (live_transitions() > 0) begin
          t       = $urandom_range(live_transitions() - 1);
          im      = in_mask_tbl[t] & pm;
          blocked = out_mask_tbl[t] & ~im & pm;
          mk      = im | (sinks & $urandom & ~blocked);
        end else begin
          mk = sinks & $urandom;
        end
      end
      4, 5:    mk = sinks & $urandom;
      6:       mk = $urandom & ~pm;
      7, 8:    mk = $urandom & $urandom & pm;
      default: mk = $urandom;
    endcase
    if ($urandom_range(1) == 0) mk |= $urandom & ~pm;
    return mk;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic check_verdict(input logic [OutDataW-1:0] data);
    verdict_t got, want;
    got = data[8:0];
    if (expected_verdicts.size() == 0) begin
      report_mismatch($sformatf("unexpected verdict %h", got));
    end else begin
      want = expected_verdicts.pop_front();
      if (got.enabled_count != want.enabled_count)
        report_mismatch($sformatf("enabled_count %0d, want %0d", got.enabled_count,
                                  want.enabled_count));
      if (got.is_dead != want.is_dead)
        report_mismatch($sformatf("is_dead %0d, want %0d", got.is_dead, want.is_dead));
      if (got.is_final != want.is_final)
        report_mismatch($sformatf("is_final %0d, want %0d", got.is_final, want.is_final));
      if (got.is_deadlock != want.is_deadlock)
        report_mismatch($sformatf("is_deadlock %0d, want %0d", got.is_deadlock,
                                  want.is_deadlock));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_verdict(m_axis_tdata);
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(input logic op, input logic [4:0] idx, input logic [31:0] im,
                           input logic [31:0] om, input logic [31:0] mk);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b000, mk, om, im, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == OpLoad) begin
      in_mask_tbl[idx]  = im;
      out_mask_tbl[idx] = om;
    end else begin
      expected_verdicts.push_back(eval_marking(mk));
    end
  endtask

  task automatic load_entry(input logic [4:0] idx, input logic [31:0] im,
                            input logic [31:0] om);
    send_item(OpLoad, idx, im, om, $urandom);
  endtask

  task automatic check_marking(input logic [31:0] mk);
    send_item(OpCheck, 5'($urandom), $urandom, $urandom, mk);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgInitMarking: init_marking_q = data;
      CfgPlaceCount:  place_count_q  = data[5:0];
      CfgTransCount:  trans_count_q  = data[5:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] init, input logic [5:0] pc,
                           input logic [5:0] tc);
    settle();
    write_reg(CfgInitMarking, init);
    write_reg(CfgPlaceCount, {($urandom_range(3) == 0) ? 26'($urandom) : 26'd0, pc});
    write_reg(CfgTransCount, {($urandom_range(3) == 0) ? 26'($urandom) : 26'd0, tc});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_net(input int unsigned n);
    for (int unsigned t = 0; t < n; t++) load_entry(5'(t), sparse_mask(3), sparse_mask(2));
  endtask

  task automatic test_reset_state();
    check_marking(32'h0);
    check_marking(32'hFFFF_FFFF);
    check_marking(32'h8000_0001);
  endtask

  task automatic test_directed_net();
    configure(32'h1, 6'd8, 6'd4);
    load_entry(5'd0, 32'h01, 32'h02);
    load_entry(5'd1, 32'h02, 32'h04);
    load_entry(5'd2, 32'h03, 32'h03);
    load_entry(5'd3, 32'hFFFF_FF10, 32'h8000_0020);
    check_marking(32'h00);
    check_marking(32'h04);
    check_marking(32'h01);
    check_marking(32'h03);
    check_marking(32'hFFFF_FF00);
    check_marking(32'h80);
    check_marking(32'h10);
    check_marking(32'h30);
    check_marking(32'h13);
    configure(32'hFFFF_FF00, 6'd8, 6'd4);
    check_marking(32'h00);
    // no sink places: every live place feeds a transition
    configure(32'h0, 6'd2, 6'd2);
    load_entry(5'd0, 32'h1, 32'h2);
    load_entry(5'd1, 32'h2, 32'h1);
    check_marking(32'h1);
    check_marking(32'h3);
    configure(32'hFFFF_FFFF, 6'd0, 6'd2);
    check_marking(32'hFFFF_FFFF);
    load_entry(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_backpressure();
    configure($urandom, 6'd6, 6'd8);
    load_net(8);
    hold_left = 400;
    repeat (20) check_marking(next_marking());
    s_axis_tvalid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (5) check_marking(next_marking());
  endtask

  task automatic test_random_nets();
    logic [31:0] init;
    logic [5:0]  pc, tc;
    int unsigned k;
    for (int unsigned phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      for (int unsigned net = 0; net < 4; net++) begin
        k = phase * 4 + net;
        case (k)
          0: begin init = '1; pc = 6'd32; tc = 6'd32; end
          1: begin init = $urandom; pc = 6'd1; tc = 6'd3; end
          2: begin init = '0; pc = 6'd63; tc = 6'd63; end
          3: begin init = $urandom; pc = 6'd0; tc = 6'd5; end
          7: begin
            init = $urandom;
            pc   = 6'($urandom_range(33, 62));
            tc   = 6'($urandom_range(33, 62));
          end
          default: begin
            init = $urandom_range(1) ? $urandom : 32'h0;
            pc   = ($urandom_range(4) == 0) ? 6'd32 : 6'($urandom_range(2, 12));
            tc   = 6'($urandom_range(1, 12));
          end
        endcase
        configure(init, pc, tc);
        load_net(live_transitions());
        repeat (30) begin
          if ($urandom_range(9) == 0)
            load_entry(5'($urandom), sparse_mask(3), sparse_mask(2));
          else
            check_marking(next_marking());
        end
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = OpLoad;
    m_axis_tready  = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CfgInitMarking;
    cfg_data_i     = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    mismatch_count = 0;
    init_marking_q = '0;
    place_count_q  = 6'd32;
    trans_count_q  = 6'd0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_directed_net();
    test_backpressure();
    test_random_nets();
    settle();
    if (mismatch_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* filelist.f */
design/pnd_pkg.sv
design/pnd_ctrl.sv
design/pnd_dpath.sv
design/petri_net_dead_marking_check_core.sv
dv/tb.sv
